// ----- src/pcsq_pkg.sv -----
// Shared types, codes and constants of the priority class service queue.
`default_nettype none
package pcsq_pkg;

    // Default number of queue slots.
    localparam int QUEUE_DEPTH = 32;

    // Field widths.
    localparam int GROUP_W  = 8;
    localparam int TICKET_W = 16;
    localparam int DESK_W   = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Reset values of the configuration registers.
    localparam logic [GROUP_W-1:0] PRIO_GROUP_RESET = 8'd80;  // ASCII 'P'
    localparam logic [DESK_W-1:0]  PRIO_DESK_RESET  = 4'd1;
    localparam logic [TICKET_W-1:0] TICKET_RESET    = 16'd1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PRIO_GROUP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRIO_DESK  = 2'd1;

    // Input item modes.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_CALL   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_SHIFT,
        ST_REPLY
    } state_t;

    // One stored queue entry.
    typedef struct packed {
        logic [GROUP_W-1:0]  group;
        logic [TICKET_W-1:0] ticket;
    } slot_t;

    // Configuration seen by the sequencer.
    typedef struct packed {
        logic [GROUP_W-1:0] prio_group;
        logic [DESK_W-1:0]  prio_desk;
    } cfg_t;

    // One result beat.
    typedef struct packed {
        status_t             status;
        logic [GROUP_W-1:0]  group;
        logic [TICKET_W-1:0] ticket;
        logic [DESK_W-1:0]   desk;
        logic                now_empty;
    } res_t;

endpackage
`default_nettype wire

// ----- src/pcsq_mem.sv -----
// Slot memory: one write port and one registered read port.
`default_nettype none
module pcsq_mem #(
    parameter int QUEUE_DEPTH = pcsq_pkg::QUEUE_DEPTH,
    localparam int ADDR_W = $clog2(QUEUE_DEPTH)
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [ADDR_W-1:0]   waddr,
    input  wire pcsq_pkg::slot_t     wdata,
    input  wire logic                re,
    input  wire logic [ADDR_W-1:0]   raddr,
    output pcsq_pkg::slot_t          rdata
);

    pcsq_pkg::slot_t mem [QUEUE_DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- src/pcsq_ctrl.sv -----
// Sequencer: insert, priority scan and queue compaction over the slot memory.
`default_nettype none
module pcsq_ctrl #(
    parameter int QUEUE_DEPTH = pcsq_pkg::QUEUE_DEPTH,
    localparam int ADDR_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire pcsq_pkg::cfg_t                  cfg,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            mode,
    input  wire logic [pcsq_pkg::GROUP_W-1:0]    group_code,
    input  wire logic [pcsq_pkg::DESK_W-1:0]     desk,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output pcsq_pkg::res_t                       res,
    output logic                                 mem_we,
    output logic [ADDR_W-1:0]                    mem_waddr,
    output pcsq_pkg::slot_t                      mem_wdata,
    output logic                                 mem_re,
    output logic [ADDR_W-1:0]                    mem_raddr,
    input  wire pcsq_pkg::slot_t                 mem_rdata
);

    pcsq_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [pcsq_pkg::TICKET_W-1:0] tkt_reg, tkt_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    pcsq_pkg::slot_t   hit_reg, hit_next;
    logic [pcsq_pkg::DESK_W-1:0] desk_reg, desk_next;
    pcsq_pkg::res_t    res_reg, res_next;

    logic accept;
    logic is_full;
    logic is_empty;
    logic is_last;
    logic group_match;

    // Compare logic: accept, full and empty tests, end-of-queue test and scan hit.
    assign accept      = in_valid && (state_reg == pcsq_pkg::ST_IDLE);
    assign is_full     = (occ_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty    = (occ_reg == '0);
    assign is_last     = ((CNT_W'(idx_reg) + CNT_W'(1)) == occ_reg);
    assign group_match = (mem_rdata.group == cfg.prio_group);

    assign in_stall  = (state_reg != pcsq_pkg::ST_IDLE);
    assign res_valid = (state_reg == pcsq_pkg::ST_REPLY);
    assign res       = res_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcsq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == pcsq_pkg::MODE_INSERT || is_empty)
                    begin
                        state_next = pcsq_pkg::ST_REPLY;
                    end
                    else if (desk == cfg.prio_desk)
                    begin
                        state_next = pcsq_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = pcsq_pkg::ST_FETCH;
                    end
                end
            end
            pcsq_pkg::ST_SCAN:
            begin
                if (group_match)
                begin
                    state_next = pcsq_pkg::ST_SHIFT;
                end
                else if (is_last)
                begin
                    state_next = pcsq_pkg::ST_FETCH;
                end
            end
            pcsq_pkg::ST_FETCH:
            begin
                state_next = pcsq_pkg::ST_SHIFT;
            end
            pcsq_pkg::ST_SHIFT:
            begin
                if (is_last)
                begin
                    state_next = pcsq_pkg::ST_REPLY;
                end
            end
            pcsq_pkg::ST_REPLY:
            begin
                if (res_ready)
                begin
                    state_next = pcsq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcsq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        occ_next  = occ_reg;
        tkt_next  = tkt_reg;
        idx_next  = idx_reg;
        hit_next  = hit_reg;
        desk_next = desk_reg;
        res_next  = res_reg;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (state_reg)
            pcsq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    desk_next = desk;
                    idx_next  = '0;
                    if (mode == pcsq_pkg::MODE_INSERT)
                    begin
                        if (is_full)
                        begin
                            res_next.status    = pcsq_pkg::STATUS_FULL;
                            res_next.group     = '0;
                            res_next.ticket    = '0;
                            res_next.desk      = '0;
                            res_next.now_empty = is_empty;
                        end
                        else
                        begin
                            // Append at the tail and issue the next ticket.
                            mem_we           = 1'b1;
                            mem_waddr        = occ_reg[ADDR_W-1:0];
                            mem_wdata.group  = group_code;
                            mem_wdata.ticket = tkt_reg;
                            occ_next         = occ_reg + CNT_W'(1);
                            tkt_next         = tkt_reg + pcsq_pkg::TICKET_W'(1);
                            res_next.status    = pcsq_pkg::STATUS_OK;
                            res_next.group     = '0;
                            res_next.ticket    = tkt_reg;
                            res_next.desk      = '0;
                            res_next.now_empty = 1'b0;
                        end
                    end
                    else if (is_empty)
                    begin
                        res_next.status    = pcsq_pkg::STATUS_EMPTY;
                        res_next.group     = '0;
                        res_next.ticket    = '0;
                        res_next.desk      = desk;
                        res_next.now_empty = 1'b1;
                    end
                    else
                    begin
                        // Fetch the head; the scan or the plain pick starts there.
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                    end
                end
            end
            pcsq_pkg::ST_SCAN:
            begin
                if (group_match)
                begin
                    hit_next  = mem_rdata;
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + ADDR_W'(1);
                end
                else if (is_last)
                begin
                    // No priority entry: fall back to the head.
                    idx_next  = '0;
                    mem_re    = 1'b1;
                    mem_raddr = '0;
                end
                else
                begin
                    idx_next  = idx_reg + ADDR_W'(1);
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + ADDR_W'(1);
                end
            end
            pcsq_pkg::ST_FETCH:
            begin
                hit_next  = mem_rdata;
                idx_next  = '0;
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(1);
            end
            pcsq_pkg::ST_SHIFT:
            begin
                if (!is_last)
                begin
                    // Move the next entry down one slot, prefetch the one after.
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = mem_rdata;
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + ADDR_W'(2);
                    idx_next  = idx_reg + ADDR_W'(1);
                end
                else
                begin
                    occ_next           = occ_reg - CNT_W'(1);
                    res_next.status    = pcsq_pkg::STATUS_OK;
                    res_next.group     = hit_reg.group;
                    res_next.ticket    = hit_reg.ticket;
                    res_next.desk      = desk_reg;
                    res_next.now_empty = (occ_reg == CNT_W'(1));
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcsq_pkg::ST_IDLE;
            occ_reg   <= '0;
            tkt_reg   <= pcsq_pkg::TICKET_RESET;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            tkt_reg   <= tkt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
        desk_reg <= desk_next;
        res_reg  <= res_next;
    end

    // The fill count never passes the queue depth.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    // Compaction writes stay inside the filled part of the queue.
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == pcsq_pkg::ST_SHIFT) |->
        ((CNT_W'(idx_reg) + CNT_W'(1)) < occ_reg))
        else $error("compaction write beyond the tail");

    // An accepted insert into a non-full queue grows it by one.
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == pcsq_pkg::MODE_INSERT && !is_full) |=>
        (occ_reg == $past(occ_reg) + CNT_W'(1)))
        else $error("insert did not grow the queue");

    // A pending result is held until the output side takes it.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_reg)))
        else $error("pending result dropped or changed");

endmodule
`default_nettype wire

// ----- src/priority_class_service_queue_unit.sv -----
// Top level of the priority class service queue: configuration, core and output register.
//
// A queue of waiting entries in arrival order, each with a group code and a
// 16-bit ticket issued here (starting at 1, wrapping to 0). An insert appends
// at the tail and goes straight to the result, as does a call on an empty queue.
// A call is served from the head, or at the priority desk from the first entry
// of the priority group, and the queue behind it is then compacted; a priority
// desk call that finds no priority entry scans the whole queue and then
// compacts it from the head. The slot memory gives one read and one write per
// cycle, which drive both the priority scan and the compaction that closes the
// gap left by the served entry. Results go to an output register, so the next
// item is accepted while a result beat still waits on out_stall.
`default_nettype none
module priority_class_service_queue_unit #(
    parameter int QUEUE_DEPTH = pcsq_pkg::QUEUE_DEPTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [pcsq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [pcsq_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 mode,
    input  wire logic [pcsq_pkg::GROUP_W-1:0]         group_code,
    input  wire logic [pcsq_pkg::DESK_W-1:0]          desk,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [1:0]                                status,
    output logic [pcsq_pkg::GROUP_W-1:0]              entry_group,
    output logic [pcsq_pkg::TICKET_W-1:0]             ticket,
    output logic [pcsq_pkg::DESK_W-1:0]               serving_desk,
    output logic                                      now_empty
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);

    pcsq_pkg::cfg_t  cfg_reg, cfg_next;
    pcsq_pkg::res_t  out_res_reg;
    logic            out_valid_reg, out_valid_next;

    pcsq_pkg::res_t  res;
    logic            res_valid;
    logic            res_ready;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    pcsq_pkg::slot_t   mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    pcsq_pkg::slot_t   mem_rdata;

    // Configuration register writes; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pcsq_pkg::CFG_PRIO_GROUP:
                begin
                    cfg_next.prio_group = cfg_data[pcsq_pkg::GROUP_W-1:0];
                end
                pcsq_pkg::CFG_PRIO_DESK:
                begin
                    cfg_next.prio_desk = cfg_data[pcsq_pkg::DESK_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prio_group <= pcsq_pkg::PRIO_GROUP_RESET;
            cfg_reg.prio_desk  <= pcsq_pkg::PRIO_DESK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Output register: loads a result beat when empty or being drained.
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign entry_group  = out_res_reg.group;
    assign ticket       = out_res_reg.ticket;
    assign serving_desk = out_res_reg.desk;
    assign now_empty    = out_res_reg.now_empty;

    // Sequencer.
    pcsq_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .group_code (group_code),
        .desk       (desk),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // Slot memory.
    pcsq_mem #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire
